/* rtl/line_substring_match_top_defines.svh */
// assertion macros for the line substring match block
`ifndef LINE_SUBSTRING_MATCH_TOP_DEFINES_SVH
`define LINE_SUBSTRING_MATCH_TOP_DEFINES_SVH
`ifndef SYNTH
`define LSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LSM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSM_ASSERT(name, prop, msg)
`define LSM_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

/* rtl/lsm_pkg.sv */
package lsm_pkg;

  localparam int MAX_LINE_DEF    = 1024;
  localparam int PATTERN_MAX_DEF = 8;

  localparam int CHAR_W    = 8;
  localparam int PAT_BYTES = 8;
  localparam int PAT_SEL_W = 3;
  localparam int LEN_W     = 4;
  localparam int OUT_POS_W = 10;
  localparam int COUNT_W   = 16;

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR    = 8'd0;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

  localparam logic [PAT_BYTES*CHAR_W-1:0] PATTERN_RESET = 64'h0000_0000_646C_756F;
  localparam logic [LEN_W-1:0]            LENGTH_RESET  = 4'd4;

  typedef logic [PAT_BYTES-1:0][CHAR_W-1:0] pat_t;

  typedef enum logic [0:0] {
    CFG_PATTERN_CHARS  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_in_line;
  } in_t;

  typedef struct packed {
    logic                 match_found;
    logic [OUT_POS_W-1:0] match_index;
    logic [OUT_POS_W-1:0] line_length;
    logic [COUNT_W-1:0]   lines_matched;
  } out_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

/* rtl/lsm_cell.sv */
module lsm_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  lsm_pkg::cell_ctl_t                ctl,
  input  logic [lsm_pkg::CHAR_W-1:0]        d,
  input  lsm_pkg::pat_t                     pattern,
  input  logic [lsm_pkg::LEN_W-1:0]         eff_len,
  output logic [lsm_pkg::CHAR_W-1:0]        q,
  output logic                              eq
);
  import lsm_pkg::*;

  logic                 active;
  logic [LEN_W-1:0]     pat_idx;
  logic [CHAR_W-1:0]    pat_byte;

  // this cell sees the character that sits INDEX places back in the window
  assign active   = LEN_W'(INDEX) < eff_len;
  assign pat_idx  = eff_len - LEN_W'(INDEX) - LEN_W'(1);
  assign pat_byte = pattern[pat_idx[PAT_SEL_W-1:0]];
  assign eq       = !active || (d == pat_byte);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= ctl.clear ? ZERO_CHAR : d;
    end
  end

endmodule

/* rtl/lsm_out_buf.sv */
module lsm_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  input  lsm_pkg::out_t wr_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output lsm_pkg::out_t out_data
);
  import lsm_pkg::*;

  logic skid_valid;
  out_t skid_data;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (wr_valid) begin
        out_data  <= wr_data;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (wr_valid) begin
      // output held by the receiver, park the new result
      skid_data  <= wr_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

/* rtl/line_substring_match_top.sv */
// latency: a line's result is registered in the output buffer on its last character transfer,
// into the skid register while the output is held; throughput: one character per cycle while in_stall is low
// the input stalls only while both the output register and the skid register hold results
// reset (synchronous, rst high) restores the pattern registers to their defaults,
// empties the window, the line state, the output stages and the matching-line count
module line_substring_match_top #(
  parameter int MAX_LINE    = lsm_pkg::MAX_LINE_DEF,
  parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  lsm_pkg::in_t                           in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output lsm_pkg::out_t                          out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  lsm_pkg::cfg_idx_t                      cfg_index,
  input  logic [lsm_pkg::PAT_BYTES*lsm_pkg::CHAR_W-1:0] cfg_data
);
  import lsm_pkg::*;
  `include "line_substring_match_top_defines.svh"

  localparam int POS_W = $clog2(MAX_LINE);
  localparam int EXT_W = POS_W + OUT_POS_W + LEN_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_LINE - 1);

  pat_t             pattern_chars;
  logic [LEN_W-1:0] pattern_length;
  logic [LEN_W-1:0] len_clip;
  logic [LEN_W-1:0] eff_len;

  logic [POS_W-1:0]   pos, pos_next, pos_inc;
  logic [POS_W-1:0]   first_start, first_start_next;
  logic               seen_match, seen_match_next;
  logic               seen_zero, seen_zero_next;
  logic [COUNT_W-1:0] match_count, match_count_next;

  logic in_acc;
  logic line_end;
  logic hit;
  logic found_now;
  logic [POS_W-1:0] index_now;
  logic [EXT_W-1:0] ext_index, ext_length;
  logic [PATTERN_MAX-1:0] eq_vec;
  logic [CHAR_W-1:0] cell_d [PATTERN_MAX];
  logic [CHAR_W-1:0] cell_q [PATTERN_MAX];
  cell_ctl_t cell_ctl;
  out_t result;
  logic buf_full;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars  <= pat_t'(PATTERN_RESET);
      pattern_length <= LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_CHARS:  pattern_chars  <= pat_t'(cfg_data);
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // usable length is the pattern length clipped to PATTERN_MAX and stops at the first zero byte of the pattern
  always_comb begin
    len_clip = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pattern_length;
    eff_len  = len_clip;
    for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
      if ((LEN_W'(k) < len_clip) && (pattern_chars[k] == ZERO_CHAR)) begin
        eff_len = LEN_W'(k);
      end
    end
  end

  assign in_stall = buf_full;
  assign in_acc   = in_valid && !in_stall;
  assign pos_inc  = pos + POS_W'(1);
  assign line_end = (in_data.char_in == NEWLINE_CHAR) || in_data.last_in_line ||
                    (pos_inc >= LAST_POS);

  // reset empties the window through the same clear path as a line end
  assign cell_ctl.shift = in_acc || rst;
  assign cell_ctl.clear = line_end || rst;

  // window chain
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_d[j] = in_data.char_in;
    end else begin : g_link
      assign cell_d[j] = cell_q[j-1];
    end
    lsm_cell #(.INDEX(j)) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .d       (cell_d[j]),
      .pattern (pattern_chars),
      .eff_len (eff_len),
      .q       (cell_q[j]),
      .eq      (eq_vec[j])
    );
  end

  assign seen_zero_next = seen_zero || (in_data.char_in == ZERO_CHAR);

  always_comb begin
    hit = (&eq_vec) && (eff_len != '0) && !seen_zero_next && !seen_match &&
          ((EXT_W'(pos_inc)) >= (EXT_W'(eff_len)));
    found_now = seen_match || hit;
    index_now = hit ? POS_W'(EXT_W'(pos_inc) - EXT_W'(eff_len)) : first_start;
    match_count_next = (found_now && (match_count != COUNT_MAX)) ?
                       match_count + COUNT_W'(1) : match_count;
    ext_index  = EXT_W'(index_now);
    ext_length = EXT_W'(pos_inc);

    result.match_found   = found_now;
    result.match_index   = found_now ? ext_index[OUT_POS_W-1:0] : '0;
    result.line_length   = ext_length[OUT_POS_W-1:0];
    result.lines_matched = match_count_next;

    if (line_end) begin
      pos_next         = '0;
      first_start_next = '0;
      seen_match_next  = 1'b0;
    end else begin
      pos_next         = pos_inc;
      first_start_next = index_now;
      seen_match_next  = found_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      first_start <= '0;
      seen_match  <= 1'b0;
      seen_zero   <= 1'b0;
      match_count <= '0;
    end else if (in_acc) begin
      pos         <= pos_next;
      first_start <= first_start_next;
      seen_match  <= seen_match_next;
      seen_zero   <= line_end ? 1'b0 : seen_zero_next;
      if (line_end) begin
        match_count <= match_count_next;
      end
    end
  end

  lsm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .wr_valid  (in_acc && line_end),
    .wr_data   (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `LSM_ASSERT_ALWAYS(a_skid_behind_out, buf_full |-> out_valid, "skid full, output empty")
  `LSM_ASSERT(a_pos_in_range, pos < LAST_POS, "line position reached the line limit")
  `LSM_ASSERT(a_window_cleared, (in_acc && line_end) |=> (cell_q[PATTERN_MAX-1] == '0), "window")
  `LSM_ASSERT(a_count_monotonic, !$past(rst) |-> (match_count >= $past(match_count)), "count")
  `LSM_ASSERT(a_index_zero_no_match, (out_valid && !out_data.match_found) |-> (out_data.match_index == '0), "index")

endmodule
